### hw/rtl/tdoa_grid_search_locator_macros.svh
// Assertion macros shared by the locator RTL.
`ifndef TDOA_GRID_SEARCH_LOCATOR_MACROS_SVH
`define TDOA_GRID_SEARCH_LOCATOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define TGSL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("locator assertion failed");

// Next-cycle implication, checked out of reset.
`define TGSL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("locator assertion failed");

`endif

### hw/rtl/tgsl_pkg.sv
// Package: types, codes and constants of the grid-search locator.
`default_nettype none
package tgsl_pkg;

  localparam int NODES_DEF = 8;

  localparam int COORD_W = 16;
  localparam int TIME_W  = 24;
  localparam int DIST_W  = 21;
  localparam int SQ_W    = 41;
  localparam int ERR_W   = 41;

  // 1000 s scaled by 85 and 2^24
  localparam logic [ERR_W-1:0] ERR_LIMIT = ERR_W'(64'd85000 << 24);

  localparam logic [1:0] FUNC_MIC  = 2'd0;
  localparam logic [1:0] FUNC_MEAS = 2'd1;
  localparam logic [1:0] FUNC_RUN  = 2'd2;

  localparam logic [1:0] REG_COLS     = 2'd0;
  localparam logic [1:0] REG_ROWS     = 2'd1;
  localparam logic [1:0] REG_STEP     = 2'd2;
  localparam logic [1:0] REG_MIN_NODE = 2'd3;

  typedef struct packed {
    logic [1:0]         func;
    logic [2:0]         node;
    logic [COORD_W-1:0] mic_a_x;
    logic [COORD_W-1:0] mic_a_y;
    logic [COORD_W-1:0] mic_b_x;
    logic [COORD_W-1:0] mic_b_y;
    logic signed [TIME_W-1:0] time_diff;
    logic               valid_req;
  } in_t;

  typedef struct packed {
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic               located;
  } out_t;

  typedef struct packed {
    logic [COORD_W-1:0] a_x;
    logic [COORD_W-1:0] a_y;
    logic [COORD_W-1:0] b_x;
    logic [COORD_W-1:0] b_y;
  } mic_t;

  // Distance unit status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } dist_sts_t;

endpackage
`default_nettype wire

### hw/rtl/tgsl_dist.sv
// Distance unit: one shared squarer, then a bit-serial integer square root.
`default_nettype none
module tgsl_dist import tgsl_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start_i,
  input  wire logic [COORD_W-1:0] px_i,
  input  wire logic [COORD_W-1:0] py_i,
  input  wire logic [COORD_W-1:0] mx_i,
  input  wire logic [COORD_W-1:0] my_i,
  output dist_sts_t               sts_o,
  output logic [DIST_W-1:0]       dist_o
);

  typedef enum logic [1:0] {D_IDLE, D_SQX, D_SQY, D_ROOT} dstate_t;

  dstate_t             state_r;
  logic [COORD_W-1:0]  dx_r, dy_r;
  logic [31:0]         sq_r;
  logic [SQ_W-1:0]     v_r;
  logic [SQ_W:0]       r_r;
  logic [SQ_W-1:0]     b_r;
  logic [DIST_W-1:0]   dist_r;
  logic                done_r;

  logic [COORD_W-1:0]  dx, dy, op;
  logic [31:0]         prod;
  logic [SQ_W:0]       rb, r_nxt;
  logic                ge;

  // absolute coordinate differences
  assign dx = (px_i >= mx_i) ? px_i - mx_i : mx_i - px_i;
  assign dy = (py_i >= my_i) ? py_i - my_i : my_i - py_i;

  // the one multiplier, squaring dx then dy
  assign op   = (state_r == D_SQX) ? dx_r : dy_r;
  assign prod = 32'(op) * 32'(op);

  // one root step
  assign rb    = r_r + (SQ_W+1)'(b_r);
  assign ge    = (SQ_W+1)'(v_r) >= rb;
  assign r_nxt = ge ? (r_r >> 1) + (SQ_W+1)'(b_r) : r_r >> 1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        D_IDLE: begin
          if (start_i) begin
            dx_r    <= dx;
            dy_r    <= dy;
            state_r <= D_SQX;
          end
        end
        D_SQX: begin
          sq_r    <= prod;
          state_r <= D_SQY;
        end
        D_SQY: begin
          v_r     <= {33'(sq_r) + 33'(prod), 8'b0};
          r_r     <= '0;
          b_r     <= {1'b1, {(SQ_W-1){1'b0}}};
          state_r <= D_ROOT;
        end
        D_ROOT: begin
          if (ge) v_r <= v_r - rb[SQ_W-1:0];
          r_r <= r_nxt;
          b_r <= b_r >> 2;
          if (b_r[0]) begin
            dist_r  <= r_nxt[DIST_W-1:0];
            done_r  <= 1'b1;
            state_r <= D_IDLE;
          end
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  assign sts_o.busy = (state_r != D_IDLE);
  assign sts_o.done = done_r;
  assign dist_o     = dist_r;

endmodule
`default_nettype wire

### hw/rtl/tdoa_grid_search_locator.sv
// Operation: load items are taken while idle; a run walks every grid point and valid node in turn.
// Each valid node costs a dispatch step, two distances in the shared squarer/root unit
// and one error step; each invalid node a skip step; each grid point one compare step.
// A run with too few valid nodes, or with zero columns or rows, answers without a grid walk.
// One item is handled at a time.
// Reset (synchronous, rst_n low) clears valid flags, restores register defaults, goes idle.
`default_nettype none
`include "tdoa_grid_search_locator_macros.svh"
module tdoa_grid_search_locator import tgsl_pkg::*; #(
  parameter int NODES = NODES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_t             out_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [12:0] cfg_data
);

  localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;

  typedef enum logic [2:0] {S_IDLE, S_NODE, S_DIST_A, S_DIST_B, S_ERR, S_POINT} state_t;

  state_t             state_r;
  logic [8:0]         cols_r, rows_r;
  logic [12:0]        step_r;
  logic [3:0]         min_nodes_r;
  mic_t               mic_r  [NODES];
  logic signed [TIME_W-1:0] meas_r [NODES];
  logic [NODES-1:0]   flags_r;
  logic [NW-1:0]      ni_r;
  logic [8:0]         kx_r, ky_r;
  logic [COORD_W-1:0] px_r, py_r, bx_r, by_r;
  logic [ERR_W-1:0]   sum_r, best_r;
  logic [DIST_W-1:0]  da_r;
  logic               msel_r, start_r;
  logic               out_valid_r;
  out_t               out_r;

  dist_sts_t          dsts;
  logic [DIST_W-1:0]  dist_len;
  mic_t               mic_cur;
  logic [COORD_W-1:0] mx, my;
  logic               in_acc, node_ok, last_node;
  logic [NW-1:0]      wr_idx;
  logic signed [21:0] dd;
  logic signed [31:0] d64, err;
  logic signed [30:0] t85;
  logic [31:0]        err_abs;

  // distance unit
  assign mic_cur = mic_r[ni_r];
  assign mx      = msel_r ? mic_cur.b_x : mic_cur.a_x;
  assign my      = msel_r ? mic_cur.b_y : mic_cur.a_y;

  tgsl_dist u_dist (
    .clk    (clk),
    .rst_n  (rst_n),
    .start_i(start_r),
    .px_i   (px_r),
    .py_i   (py_r),
    .mx_i   (mx),
    .my_i   (my),
    .sts_o  (dsts),
    .dist_o (dist_len)
  );

  // saturating grid coordinate step
  function automatic logic [COORD_W-1:0] coord_inc(input logic [COORD_W-1:0] c,
                                                   input logic [12:0] s);
    logic [COORD_W:0] t;
    t = (COORD_W+1)'(c) + (COORD_W+1)'(s);
    return t[COORD_W] ? {COORD_W{1'b1}} : t[COORD_W-1:0];
  endfunction

  // node error, scaled by 85: |D*64 - t*85| (dist_len holds distance to B here)
  assign dd      = $signed({1'b0, da_r}) - $signed({1'b0, dist_len});
  assign d64     = 32'(dd) <<< 6;
  assign t85     = 31'(meas_r[ni_r]) * 31'sd85;
  assign err     = d64 - 32'(t85);
  assign err_abs = err[31] ? 32'(-err) : 32'(err);

  assign in_acc    = in_valid && !in_stall;
  assign node_ok   = 32'(in_data.node) < NODES;
  assign wr_idx    = NW'(in_data.node);
  assign last_node = (ni_r == NW'(NODES - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      flags_r     <= '0;
      out_valid_r <= 1'b0;
      start_r     <= 1'b0;
      cols_r      <= 9'd40;
      rows_r      <= 9'd40;
      step_r      <= 13'd410;
      min_nodes_r <= 4'd4;
    end else begin
      start_r <= 1'b0;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      // configuration writes
      if (cfg_we) begin
        case (cfg_addr)
          REG_COLS:     cols_r      <= cfg_data[8:0];
          REG_ROWS:     rows_r      <= cfg_data[8:0];
          REG_STEP:     step_r      <= cfg_data;
          REG_MIN_NODE: min_nodes_r <= cfg_data[3:0];
          default: ;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            case (in_data.func)
              FUNC_MIC: begin
                if (node_ok) mic_r[wr_idx] <= {in_data.mic_a_x, in_data.mic_a_y,
                                               in_data.mic_b_x, in_data.mic_b_y};
              end
              FUNC_MEAS: begin
                if (node_ok) begin
                  meas_r[wr_idx]  <= in_data.time_diff;
                  flags_r[wr_idx] <= in_data.valid_req;
                end
              end
              FUNC_RUN: begin
                if ($countones(flags_r) < 32'(min_nodes_r)) begin
                  out_r       <= '0;
                  out_valid_r <= 1'b1;
                end else if (cols_r == '0 || rows_r == '0) begin
                  out_r       <= '{pos_x: '0, pos_y: '0, located: 1'b1};
                  out_valid_r <= 1'b1;
                  flags_r     <= '0;
                end else begin
                  kx_r    <= '0;
                  ky_r    <= '0;
                  px_r    <= '0;
                  py_r    <= '0;
                  bx_r    <= '0;
                  by_r    <= '0;
                  best_r  <= ERR_LIMIT;
                  sum_r   <= '0;
                  ni_r    <= '0;
                  state_r <= S_NODE;
                end
              end
              default: ;
            endcase
          end
        end
        // skip invalid nodes, else launch distance to mic A
        S_NODE: begin
          if (flags_r[ni_r]) begin
            msel_r  <= 1'b0;
            start_r <= 1'b1;
            state_r <= S_DIST_A;
          end else if (last_node) begin
            state_r <= S_POINT;
          end else begin
            ni_r <= ni_r + 1'b1;
          end
        end
        S_DIST_A: begin
          if (dsts.done) begin
            da_r    <= dist_len;
            msel_r  <= 1'b1;
            start_r <= 1'b1;
            state_r <= S_DIST_B;
          end
        end
        S_DIST_B: begin
          if (dsts.done) state_r <= S_ERR;
        end
        // accumulate this node's error
        S_ERR: begin
          sum_r <= sum_r + ERR_W'(err_abs);
          if (last_node) begin
            state_r <= S_POINT;
          end else begin
            ni_r    <= ni_r + 1'b1;
            state_r <= S_NODE;
          end
        end
        // keep first strict minimum, then step the grid (x outer, y inner)
        S_POINT: begin
          if (sum_r < best_r) begin
            best_r <= sum_r;
            bx_r   <= px_r;
            by_r   <= py_r;
          end
          sum_r   <= '0;
          ni_r    <= '0;
          state_r <= S_NODE;
          if (10'(ky_r) + 10'd1 == 10'(rows_r)) begin
            ky_r <= '0;
            py_r <= '0;
            kx_r <= kx_r + 1'b1;
            px_r <= coord_inc(px_r, step_r);
            if (10'(kx_r) + 10'd1 == 10'(cols_r)) begin
              out_r.pos_x   <= (sum_r < best_r) ? px_r : bx_r;
              out_r.pos_y   <= (sum_r < best_r) ? py_r : by_r;
              out_r.located <= 1'b1;
              out_valid_r   <= 1'b1;
              flags_r       <= '0;
              state_r       <= S_IDLE;
            end
          end else begin
            ky_r <= ky_r + 1'b1;
            py_r <= coord_inc(py_r, step_r);
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  `TGSL_ASSERT_IMP(a_start_idle, start_r, !dsts.busy)
  `TGSL_ASSERT_IMP(a_unlocated_zero, out_valid_r && !out_r.located,
                   out_r.pos_x == '0 && out_r.pos_y == '0)
  `TGSL_ASSERT_IMP(a_flags_cleared, $rose(out_valid_r) && out_r.located, flags_r == '0)
  `TGSL_ASSERT_NXT(a_done_leaves, state_r == S_DIST_B && dsts.done, state_r == S_ERR)

endmodule
`default_nettype wire
